/* rtl/lbfl_pkg.sv */
// Shared types, constants and helpers for the linked buffer free list.
// Used by every module of the block; has no dependencies of its own.
package lbfl_pkg;

    localparam int POOL_DEPTH = 256;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int LINK_W     = IDX_W + 1;

    localparam logic [LINK_W-1:0] NULL_MARK       = LINK_W'(POOL_DEPTH);
    localparam logic [LINK_W-1:0] POOL_COUNT_RESET = LINK_W'(POOL_DEPTH);

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ALU_INC,
        ALU_ADD,
        ALU_SUB
    } alu_mode_t;

    typedef struct packed {
        alu_mode_t         mode;
        logic [LINK_W-1:0] a;
        logic [LINK_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [LINK_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } link_req_t;

    function automatic logic is_null(input logic [LINK_W-1:0] d);
        return d >= NULL_MARK;
    endfunction

endpackage

/* rtl/lbfl_link_ram.sv */
// Next-link memory: one link per buffer, one write and one registered read a cycle.
// Depends on lbfl_pkg.
module lbfl_link_ram
    import lbfl_pkg::*;
(
    input  logic              clk,
    input  link_req_t         req,
    output logic [LINK_W-1:0] rdata
);

    logic [LINK_W-1:0] mem [POOL_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

/* rtl/lbfl_alu.sv */
// Shared arithmetic unit: increment, add or subtract with carry or borrow out.
// Depends on lbfl_pkg.
module lbfl_alu
    import lbfl_pkg::*;
(
    input  alu_req_t        req,
    output logic [LINK_W:0] res
);

    always_comb
    begin
        unique case (req.mode)
            ALU_INC: res = {1'b0, req.a} + (LINK_W + 1)'(1);
            ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
            ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
            default: res = '0;
        endcase
    end

endmodule

/* rtl/lbfl_seq.sv */
// Sequencer that walks the link memory for init, allocate and free requests.
// Depends on lbfl_pkg; drives lbfl_link_ram and lbfl_alu.
module lbfl_seq
    import lbfl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        opcode,
    input  logic [LINK_W-1:0] chain_length,
    input  logic [IDX_W-1:0]  chain_head,
    input  logic [LINK_W-1:0] pool_n,
    output logic              busy,
    output logic              done,
    output logic              ok,
    output logic [IDX_W-1:0]  head_index,
    output logic [LINK_W-1:0] free_total,
    output link_req_t         link,
    input  logic [LINK_W-1:0] link_rdata,
    output alu_req_t          alu,
    input  logic [LINK_W:0]   alu_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ACHK,
        S_AWALK,
        S_ADONE,
        S_FWALK,
        S_FDONE
    } state_t;

    state_t            state_reg, state_next;
    logic [LINK_W-1:0] len_reg, len_next;
    logic [IDX_W-1:0]  p_reg, p_next;
    logic [LINK_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [LINK_W-1:0] new_head_reg, new_head_next;
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [LINK_W-1:0] free_count_reg, free_count_next;
    logic              done_reg, done_next;
    logic              ok_reg, ok_next;
    logic [IDX_W-1:0]  head_index_reg, head_index_next;

    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        p_next          = p_reg;
        cnt_next        = cnt_reg;
        head_next       = head_reg;
        new_head_next   = new_head_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        done_next       = 1'b0;
        ok_next         = ok_reg;
        head_index_next = head_index_reg;
        link            = '0;
        alu.mode        = ALU_INC;
        alu.a           = cnt_reg;
        alu.b           = len_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (opcode)
                        OP_INIT:
                        begin
                            cnt_next   = '0;
                            state_next = S_INIT;
                        end
                        OP_ALLOC:
                        begin
                            len_next   = chain_length;
                            state_next = S_ACHK;
                        end
                        OP_FREE:
                        begin
                            link.re    = 1'b1;
                            link.raddr = chain_head;
                            p_next     = chain_head;
                            head_next  = chain_head;
                            cnt_next   = LINK_W'(1);
                            state_next = S_FWALK;
                        end
                        default:
                        begin
                            done_next       = 1'b1;
                            ok_next         = 1'b0;
                            head_index_next = '0;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                alu.mode   = ALU_INC;
                alu.a      = cnt_reg;
                cnt_next   = alu_res[LINK_W-1:0];
                link.we    = 1'b1;
                link.waddr = cnt_reg[IDX_W-1:0];
                if (alu_res == {1'b0, pool_n})
                begin
                    link.wdata      = NULL_MARK;
                    free_head_next  = '0;
                    free_count_next = pool_n;
                    done_next       = 1'b1;
                    ok_next         = 1'b1;
                    head_index_next = '0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    link.wdata = alu_res[LINK_W-1:0];
                end
            end
            S_ACHK:
            begin
                alu.mode = ALU_SUB;
                alu.a    = free_count_reg;
                alu.b    = len_reg;
                if (len_reg == '0 || alu_res[LINK_W] || is_null(free_head_reg))
                begin
                    done_next       = 1'b1;
                    ok_next         = 1'b0;
                    head_index_next = '0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    link.re    = 1'b1;
                    link.raddr = free_head_reg[IDX_W-1:0];
                    p_next     = free_head_reg[IDX_W-1:0];
                    head_next  = free_head_reg[IDX_W-1:0];
                    cnt_next   = LINK_W'(1);
                    state_next = S_AWALK;
                end
            end
            S_AWALK:
            begin
                alu.mode = ALU_INC;
                alu.a    = cnt_reg;
                if (cnt_reg == len_reg)
                begin
                    link.we       = 1'b1;
                    link.waddr    = p_reg;
                    link.wdata    = NULL_MARK;
                    new_head_next = link_rdata;
                    state_next    = S_ADONE;
                end
                else if (is_null(link_rdata))
                begin
                    done_next       = 1'b1;
                    ok_next         = 1'b0;
                    head_index_next = '0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cnt_next   = alu_res[LINK_W-1:0];
                    p_next     = link_rdata[IDX_W-1:0];
                    link.re    = 1'b1;
                    link.raddr = link_rdata[IDX_W-1:0];
                end
            end
            S_ADONE:
            begin
                alu.mode        = ALU_SUB;
                alu.a           = free_count_reg;
                alu.b           = len_reg;
                free_count_next = alu_res[LINK_W-1:0];
                free_head_next  = new_head_reg;
                done_next       = 1'b1;
                ok_next         = 1'b1;
                head_index_next = head_reg;
                state_next      = S_IDLE;
            end
            S_FWALK:
            begin
                alu.mode = ALU_INC;
                alu.a    = cnt_reg;
                if (is_null(link_rdata))
                begin
                    state_next = S_FDONE;
                end
                else if (cnt_reg == NULL_MARK)
                begin
                    done_next       = 1'b1;
                    ok_next         = 1'b0;
                    head_index_next = '0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cnt_next   = alu_res[LINK_W-1:0];
                    p_next     = link_rdata[IDX_W-1:0];
                    link.re    = 1'b1;
                    link.raddr = link_rdata[IDX_W-1:0];
                end
            end
            S_FDONE:
            begin
                alu.mode   = ALU_ADD;
                alu.a      = free_count_reg;
                alu.b      = cnt_reg;
                link.we    = 1'b1;
                link.waddr = p_reg;
                link.wdata = free_head_reg;
                if (alu_res > {1'b0, NULL_MARK})
                begin
                    free_count_next = NULL_MARK;
                end
                else
                begin
                    free_count_next = alu_res[LINK_W-1:0];
                end
                free_head_next  = {1'b0, head_reg};
                done_next       = 1'b1;
                ok_next         = 1'b1;
                head_index_next = '0;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            len_reg        <= '0;
            p_reg          <= '0;
            cnt_reg        <= '0;
            head_reg       <= '0;
            new_head_reg   <= NULL_MARK;
            free_head_reg  <= NULL_MARK;
            free_count_reg <= '0;
            done_reg       <= 1'b0;
            ok_reg         <= 1'b0;
            head_index_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            p_reg          <= p_next;
            cnt_reg        <= cnt_next;
            head_reg       <= head_next;
            new_head_reg   <= new_head_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            done_reg       <= done_next;
            ok_reg         <= ok_next;
            head_index_reg <= head_index_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign ok         = ok_reg;
    assign head_index = head_index_reg;
    assign free_total = free_count_reg;

endmodule

/* rtl/linked_buffer_free_list.sv */
// Top level of the linked buffer free list: pool size register and unit wiring.
// Depends on lbfl_pkg, lbfl_link_ram, lbfl_alu and lbfl_seq.
//
// A request is taken when start is high and busy is low; its result shows on
// ok, head_index and free_total for the one cycle that done is high, and the
// receiver cannot hold it off. Work is paced by the link memory, which gives
// one registered read per cycle, so allocate and free walk a chain one buffer
// at a time. Init writes one link per buffer; allocate is checked first and
// may be refused up front before it walks the free list; free walks the given
// chain and links it onto the free list; an unused opcode is answered at once.
// Busy is low again in the cycle the result shows.
module linked_buffer_free_list
    import lbfl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        opcode,
    input  logic [LINK_W-1:0] chain_length,
    input  logic [IDX_W-1:0]  chain_head,
    output logic              done,
    output logic              ok,
    output logic [IDX_W-1:0]  head_index,
    output logic [LINK_W-1:0] free_total,
    input  logic              cfg_we,
    input  logic [LINK_W-1:0] cfg_wdata
);

    logic [LINK_W-1:0] pool_count_reg;
    logic [LINK_W-1:0] pool_n;
    link_req_t         link;
    logic [LINK_W-1:0] link_rdata;
    alu_req_t          alu;
    logic [LINK_W:0]   alu_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_count_reg <= POOL_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            pool_count_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        priority if (pool_count_reg == '0)
        begin
            pool_n = LINK_W'(1);
        end
        else if (pool_count_reg > LINK_W'(POOL_DEPTH))
        begin
            pool_n = LINK_W'(POOL_DEPTH);
        end
        else
        begin
            pool_n = pool_count_reg;
        end
    end

    lbfl_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .opcode       (opcode),
        .chain_length (chain_length),
        .chain_head   (chain_head),
        .pool_n       (pool_n),
        .busy         (busy),
        .done         (done),
        .ok           (ok),
        .head_index   (head_index),
        .free_total   (free_total),
        .link         (link),
        .link_rdata   (link_rdata),
        .alu          (alu),
        .alu_res      (alu_res)
    );

    lbfl_link_ram u_ram (
        .clk   (clk),
        .req   (link),
        .rdata (link_rdata)
    );

    lbfl_alu u_alu (
        .req (alu),
        .res (alu_res)
    );

endmodule

/* rtl/lbfl_checker.sv */
// Port-level checks for the linked buffer free list, bound to the top level.
// Depends on lbfl_pkg and linked_buffer_free_list.
module lbfl_checker
    import lbfl_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic              ok,
    input logic [IDX_W-1:0]  head_index,
    input logic [LINK_W-1:0] free_total
);

    // An accepted request either starts work or answers at once.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted request neither started nor answered");

    // A result is only shown once the block has gone idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    // When a result shows, the free count does not exceed the pool depth.
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> free_total <= LINK_W'(POOL_DEPTH))
        else $error("free count beyond pool depth");

    // A failed request reports a head index of zero.
    a_fail_head: assert property (@(posedge clk) disable iff (!rst_n)
        done && !ok |-> head_index == '0)
        else $error("failed request reports a head index");

endmodule

bind linked_buffer_free_list lbfl_checker u_lbfl_checker (.*);
